// File: rtl/digit_sum_key_sorter_macros.svh
// Assertion macros shared by the sorter RTL.
// Each macro expects clk and rst_n in scope at the place of use.
`ifndef DIGIT_SUM_KEY_SORTER_MACROS_SVH
`define DIGIT_SUM_KEY_SORTER_MACROS_SVH

// Same-cycle implication, checked only out of reset.
`define DSKS_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sorter same-cycle check failed");

// Next-cycle implication, checked only out of reset.
`define DSKS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sorter next-cycle check failed");

`endif

// File: rtl/dsks_pkg.sv
package dsks_pkg;

    // Storage and field sizes.
    localparam int MAX_ITEMS = 64;
    localparam int VALUE_W   = 32;
    localparam int KEY_W     = 8;
    localparam int SUM_W     = 7;
    localparam int CNT_W     = $clog2(MAX_ITEMS + 1);

    // Division by ten through a reciprocal: q = (x * RECIP10) >> RECIP_SHIFT,
    // exact for every 32-bit unsigned x.
    localparam logic [VALUE_W-1:0] RECIP10     = 32'hCCCC_CCCD;
    localparam int                 RECIP_SHIFT = 35;

    // One held entry: digit-sum key and the value itself.
    typedef struct packed {
        logic signed [KEY_W-1:0]   key;
        logic signed [VALUE_W-1:0] value;
    } entry_t;

    // Per-cycle command broadcast to every cell.
    typedef struct packed {
        logic insert;
        logic shift;
    } cell_ctl_t;

    // Result of the digit-sum unit.
    typedef struct packed {
        logic                    done;
        logic signed [KEY_W-1:0] key;
    } key_res_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_KEY,
        ST_EMIT
    } state_t;

    // True when a sorts strictly before b: key first, then value.
    function automatic logic sorts_before(entry_t a, entry_t b);
        logic result;
        if (a.key != b.key)
        begin
            result = ($signed(a.key) < $signed(b.key));
        end
        else
        begin
            result = ($signed(a.value) < $signed(b.value));
        end
        return result;
    endfunction

endpackage

// File: rtl/dsks_digit_unit.sv
module dsks_digit_unit (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            load,
    input  logic [dsks_pkg::VALUE_W-1:0]    load_value,
    output dsks_pkg::key_res_t              res
);
    import dsks_pkg::*;

    logic [VALUE_W-1:0]     mag_reg;
    logic [SUM_W-1:0]       sum_reg;
    logic                   neg_reg;
    logic                   run_reg;

    logic [2*VALUE_W-1:0]   prod;
    logic [VALUE_W-1:0]     quot;
    logic [VALUE_W-1:0]     quot_x10;
    logic [3:0]             digit;
    logic [VALUE_W-1:0]     abs_value;
    logic [KEY_W-1:0]       sum_ext;

    // Magnitude of the loaded value; the most negative value wraps to 2^31.
    assign abs_value = load_value[VALUE_W-1] ? (VALUE_W'(0) - load_value) : load_value;

    // One decimal digit per cycle: quotient by reciprocal, remainder by subtract.
    assign prod     = (2*VALUE_W)'(mag_reg) * (2*VALUE_W)'(RECIP10);
    assign quot     = VALUE_W'(prod[2*VALUE_W-1:RECIP_SHIFT]);
    assign quot_x10 = (quot << 3) + (quot << 1);
    assign digit    = 4'(mag_reg - quot_x10);

    // Control: runs from load until the magnitude is used up.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= 1'b0;
        end
        else if (load)
        begin
            run_reg <= 1'b1;
        end
        else if (run_reg && (mag_reg == '0))
        begin
            run_reg <= 1'b0;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            mag_reg <= abs_value;
            sum_reg <= '0;
            neg_reg <= load_value[VALUE_W-1];
        end
        else if (run_reg && (mag_reg != '0))
        begin
            mag_reg <= quot;
            sum_reg <= sum_reg + SUM_W'(digit);
        end
    end

    // A negative value takes the negated digit sum.
    assign sum_ext  = KEY_W'(sum_reg);
    assign res.done = run_reg && (mag_reg == '0);
    assign res.key  = neg_reg ? (KEY_W'(0) - sum_ext) : sum_ext;

endmodule

// File: rtl/dsks_cell.sv
module dsks_cell (
    input  logic                    clk,
    input  dsks_pkg::cell_ctl_t     ctl,
    input  logic                    occupied,
    input  dsks_pkg::entry_t        new_entry,
    input  dsks_pkg::entry_t        left_entry,
    input  logic                    left_keep,
    input  dsks_pkg::entry_t        right_entry,
    output dsks_pkg::entry_t        entry,
    output logic                    keep
);
    import dsks_pkg::*;

    entry_t entry_reg;

    // The held entry stays put unless the new item sorts strictly before it.
    assign keep  = occupied && !sorts_before(new_entry, entry_reg);
    assign entry = entry_reg;

    // Insert: take the new item at the boundary, else the left neighbor.
    // Shift: move one place toward the head while the batch drains.
    always_ff @(posedge clk)
    begin
        if (ctl.insert)
        begin
            if (!keep)
            begin
                entry_reg <= left_keep ? new_entry : left_entry;
            end
        end
        else if (ctl.shift)
        begin
            entry_reg <= right_entry;
        end
    end

endmodule

// File: rtl/digit_sum_key_sorter.sv
// Batch sorter keyed by decimal digit sum. Values are loaded one item at a time
// with start while busy is low; item_last closes the batch. Each item keeps the
// block busy from the accept edge until the digit-sum unit, which peels off one
// digit per cycle from the value's magnitude (0 to 10 decimal digits), is done,
// so the next item is accepted only after the current one is inserted. The
// insertion into the row of cells takes place in the last busy cycle of the
// item. After the closing item the block strobes the n held values out on
// consecutive cycles, in ascending key order (the digit sum, negated for a
// negative value) with ties broken by ascending value, and sorted_last marks
// the final one. The receiver cannot stall: each result is on the ports for
// exactly one cycle. Up to 64 values are held per batch; further values are dropped.
`include "digit_sum_key_sorter_macros.svh"

module digit_sum_key_sorter (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic signed [dsks_pkg::VALUE_W-1:0] item_value,
    input  logic                            item_last,
    output logic                            strobe,
    output logic signed [dsks_pkg::VALUE_W-1:0] sorted_value,
    output logic                            sorted_last
);
    import dsks_pkg::*;

    state_t             state_reg;
    state_t             state_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic [VALUE_W-1:0] pend_value_reg;
    logic               pend_last_reg;

    logic               load;
    logic               full;
    key_res_t           key_res;
    cell_ctl_t          ctl;
    entry_t             new_entry;
    entry_t             cell_entry [MAX_ITEMS];
    logic [MAX_ITEMS-1:0] cell_keep;

    // Digit-sum unit.
    dsks_digit_unit u_digit (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (load),
        .load_value (item_value),
        .res        (key_res)
    );

    assign full            = (count_reg == CNT_W'(MAX_ITEMS));
    assign new_entry.key   = key_res.key;
    assign new_entry.value = pend_value_reg;

    // Row of cells, kept sorted from the head (cell 0).
    for (genvar i = 0; i < MAX_ITEMS; i++)
    begin : g_cell
        entry_t left_e;
        entry_t right_e;
        logic   left_k;

        if (i == 0)
        begin : g_head
            assign left_e = new_entry;
            assign left_k = 1'b1;
        end
        else
        begin : g_body
            assign left_e = cell_entry[i-1];
            assign left_k = cell_keep[i-1];
        end

        if (i == MAX_ITEMS - 1)
        begin : g_tail
            assign right_e = '0;
        end
        else
        begin : g_inner
            assign right_e = cell_entry[i+1];
        end

        dsks_cell u_cell (
            .clk         (clk),
            .ctl         (ctl),
            .occupied    (CNT_W'(i) < count_reg),
            .new_entry   (new_entry),
            .left_entry  (left_e),
            .left_keep   (left_k),
            .right_entry (right_e),
            .entry       (cell_entry[i]),
            .keep        (cell_keep[i])
        );
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_KEY;
                end
            end
            ST_KEY:
            begin
                if (key_res.done)
                begin
                    state_next = pend_last_reg ? ST_EMIT : ST_IDLE;
                end
            end
            ST_EMIT:
            begin
                if (count_reg == CNT_W'(1))
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs and cell commands.
    always_comb
    begin
        busy         = 1'b1;
        load         = 1'b0;
        strobe       = 1'b0;
        ctl.insert   = 1'b0;
        ctl.shift    = 1'b0;
        sorted_value = cell_entry[0].value;
        sorted_last  = (count_reg == CNT_W'(1));
        unique case (state_reg)
            ST_IDLE:
            begin
                busy = 1'b0;
                load = start;
            end
            ST_KEY:
            begin
                ctl.insert = key_res.done && !full;
            end
            ST_EMIT:
            begin
                strobe    = 1'b1;
                ctl.shift = 1'b1;
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

    // Fill count while loading, remaining results while draining.
    always_comb
    begin
        count_next = count_reg;
        if (ctl.insert)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (ctl.shift)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    // Pending item, held while its key is computed.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            pend_value_reg <= item_value;
            pend_last_reg  <= item_last;
        end
    end

    // Checks.
    `DSKS_ASSERT_NEXT(a_emit_contiguous, strobe && !sorted_last, strobe)
    `DSKS_ASSERT_NEXT(a_idle_after_last, strobe && sorted_last, !busy && count_reg == '0)
    `DSKS_ASSERT_IMPL(a_count_bound, 1'b1, count_reg <= CNT_W'(MAX_ITEMS))
    `DSKS_ASSERT_NEXT(a_accept_to_key, start && !busy, state_reg == ST_KEY && !strobe)

endmodule
